@@ design/sbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants of the serial bank switch mapper: bus and
// result words, access kinds, queue command format and register codes.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // Sizes
  localparam int unsigned WORK_RAM_BYTES_DEF = 8192;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned WRAM_OFS_W         = 13;  // 8K window 0x6000-0x7FFF
  localparam int unsigned MAP_W              = 18;

  // Access kinds
  typedef enum logic [2:0] {
    KIND_CPU_RD   = 3'd0,
    KIND_CPU_WR   = 3'd1,
    KIND_PPU_RD   = 3'd2,
    KIND_PPU_WR   = 3'd3,
    KIND_CART_RST = 3'd4
  } kind_e;

  // Serial register targets, chosen by address bits 14:13
  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG      = 2'd3
  } target_e;

  // PRG banking modes, control bits 3:2
  typedef enum logic [1:0] {
    PRG_MODE_32K_A = 2'd0,
    PRG_MODE_32K_B = 2'd1,
    PRG_MODE_FIX_LOW  = 2'd2,
    PRG_MODE_FIX_HIGH = 2'd3
  } prg_mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_PRG_BANK_COUNT = 1'b0,
    CFG_CHR_BANK_COUNT = 1'b1
  } cfg_index_e;

  // Back-end operation of a queued command
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_RAM_RD = 2'd1,
    OP_RAM_WR = 2'd2
  } op_e;

  // Reset values
  localparam logic [4:0] CTRL_RESET            = 5'h1C;
  localparam logic [4:0] CTRL_PRG_MODE_FORCE   = 5'h0C;
  localparam logic [1:0] MIRROR_RESET          = 2'd3;
  localparam logic [4:0] PRG_BANK_COUNT_RESET  = 5'd16;
  localparam logic [5:0] CHR_BANK_COUNT_RESET  = 6'd0;
  localparam logic [2:0] SHIFT_LAST            = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic              handled;
    logic              to_rom;
    logic [MAP_W-1:0]  mapped_address;
    logic [7:0]        read_data;
    logic [1:0]        mirroring;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic       index;
    logic [5:0] data;
  } cfg_wr_t;

  typedef struct packed {
    op_e                   op;
    logic                  handled;
    logic                  to_rom;
    logic [MAP_W-1:0]      mapped;
    logic [1:0]            mirror;
    logic [WRAM_OFS_W-1:0] ram_addr;
    logic [7:0]            wdata;
  } cmd_t;

endpackage

@@ design/sbsm_ram.sv @@
// ----------------------------------------------------------------------------
// sbsm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sbsm_front.sv @@
// ----------------------------------------------------------------------------
// sbsm_front
// Accepts bus words, runs the serial register and bank registers, and turns
// each word into a command for the back end with the mapped address done.
// ----------------------------------------------------------------------------
module sbsm_front import sbsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_wr_t  cfg_i,
  input  logic     take_i,
  input  in_word_t in_word_i,
  output cmd_t     cmd_o
);

  logic [4:0] prg_count_q, prg_count_d;
  logic [5:0] chr_count_q, chr_count_d;
  logic [4:0] shift_value_q, shift_value_d;
  logic [2:0] shift_count_q, shift_count_d;
  logic [4:0] control_q, control_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [3:0] chr_full_q, chr_full_d;
  logic [3:0] prg_low_q, prg_low_d;
  logic [3:0] prg_high_q, prg_high_d;
  logic [2:0] prg_full_q, prg_full_d;
  logic [1:0] mirror_q, mirror_d;

  logic [3:0]  last_bank;
  logic [4:0]  shifted;
  logic [15:0] addr;
  logic        in_wram;
  logic        in_prg;
  logic        in_chr;
  logic [3:0]  prg_bank;
  logic [4:0]  chr_bank;
  prg_mode_e   prg_mode;

  assign addr      = in_word_i.addr;
  assign in_wram   = (addr[15:13] == 3'b011);
  assign in_prg    = addr[15];
  assign in_chr    = (addr[15:13] == 3'b000);
  assign last_bank = prg_count_q[3:0] - 4'd1;
  assign shifted   = {in_word_i.write_data[0], shift_value_q[4:1]};
  assign prg_bank  = addr[14] ? prg_high_q : prg_low_q;
  assign chr_bank  = addr[12] ? chr_high_q : chr_low_q;
  assign prg_mode  = prg_mode_e'(control_q[3:2]);

  // Configuration writes
  always_comb begin
    prg_count_d = prg_count_q;
    chr_count_d = chr_count_q;
    if (cfg_i.valid) begin
      unique case (cfg_index_e'(cfg_i.index))
        CFG_PRG_BANK_COUNT: prg_count_d = cfg_i.data[4:0];
        CFG_CHR_BANK_COUNT: chr_count_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // Decode the word, update mapper state and build the command
  always_comb begin
    shift_value_d = shift_value_q;
    shift_count_d = shift_count_q;
    control_d     = control_q;
    chr_low_d     = chr_low_q;
    chr_high_d    = chr_high_q;
    chr_full_d    = chr_full_q;
    prg_low_d     = prg_low_q;
    prg_high_d    = prg_high_q;
    prg_full_d    = prg_full_q;
    mirror_d      = mirror_q;

    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.ram_addr = addr[WRAM_OFS_W-1:0];
    cmd_o.wdata    = in_word_i.write_data;

    unique case (in_word_i.kind)
      KIND_CPU_RD: begin
        if (in_wram) begin
          cmd_o.handled = 1'b1;
          cmd_o.op      = OP_RAM_RD;
        end else if (in_prg) begin
          cmd_o.handled = 1'b1;
          cmd_o.to_rom  = 1'b1;
          if (control_q[3]) begin
            cmd_o.mapped = {prg_bank, addr[13:0]};
          end else begin
            cmd_o.mapped = {prg_full_q, addr[14:0]};
          end
        end
      end
      KIND_CPU_WR: begin
        if (in_wram) begin
          cmd_o.handled = 1'b1;
          cmd_o.op      = OP_RAM_WR;
        end else if (in_prg) begin
          cmd_o.handled = 1'b1;
          if (in_word_i.write_data[7]) begin
            shift_value_d = '0;
            shift_count_d = '0;
            control_d     = control_q | CTRL_PRG_MODE_FORCE;
          end else if (shift_count_q >= SHIFT_LAST) begin
            shift_value_d = '0;
            shift_count_d = '0;
            // Commit the fifth bit to the addressed register
            unique case (target_e'(addr[14:13]))
              TGT_CONTROL: begin
                control_d = shifted;
                mirror_d  = shifted[1:0];
              end
              TGT_CHR_LOW: begin
                if (control_q[4]) begin
                  chr_low_d = shifted;
                end else begin
                  chr_full_d = shifted[4:1];
                end
              end
              TGT_CHR_HIGH: begin
                if (control_q[4]) begin
                  chr_high_d = shifted;
                end
              end
              TGT_PRG: begin
                unique case (prg_mode)
                  PRG_MODE_32K_A, PRG_MODE_32K_B: prg_full_d = shifted[3:1];
                  PRG_MODE_FIX_LOW: begin
                    prg_low_d  = '0;
                    prg_high_d = shifted[3:0];
                  end
                  PRG_MODE_FIX_HIGH: begin
                    prg_low_d  = shifted[3:0];
                    prg_high_d = last_bank;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end else begin
            shift_value_d = shifted;
            shift_count_d = shift_count_q + 3'd1;
          end
        end
      end
      KIND_PPU_RD: begin
        if (in_chr) begin
          cmd_o.handled = 1'b1;
          cmd_o.to_rom  = 1'b1;
          if (chr_count_q == '0) begin
            cmd_o.mapped = MAP_W'(addr);
          end else if (control_q[4]) begin
            cmd_o.mapped = {1'b0, chr_bank, addr[11:0]};
          end else begin
            cmd_o.mapped = {1'b0, chr_full_q, addr[12:0]};
          end
        end
      end
      KIND_PPU_WR: begin
        if (in_chr && (chr_count_q == '0)) begin
          cmd_o.handled = 1'b1;
          cmd_o.to_rom  = 1'b1;
          cmd_o.mapped  = MAP_W'(addr);
        end
      end
      KIND_CART_RST: begin
        shift_value_d = '0;
        shift_count_d = '0;
        control_d     = CTRL_RESET;
        chr_low_d     = '0;
        chr_high_d    = '0;
        chr_full_d    = '0;
        prg_low_d     = '0;
        prg_high_d    = last_bank;
        prg_full_d    = '0;
      end
      default: ;
    endcase

    cmd_o.mirror = mirror_d;
  end

  // Hold state; advance on a taken word or a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= PRG_BANK_COUNT_RESET;
      chr_count_q   <= CHR_BANK_COUNT_RESET;
      shift_value_q <= '0;
      shift_count_q <= '0;
      control_q     <= CTRL_RESET;
      chr_low_q     <= '0;
      chr_high_q    <= '0;
      chr_full_q    <= '0;
      prg_low_q     <= '0;
      prg_high_q    <= PRG_BANK_COUNT_RESET[3:0] - 4'd1;
      prg_full_q    <= '0;
      mirror_q      <= MIRROR_RESET;
    end else begin
      prg_count_q <= prg_count_d;
      chr_count_q <= chr_count_d;
      if (take_i) begin
        shift_value_q <= shift_value_d;
        shift_count_q <= shift_count_d;
        control_q     <= control_d;
        chr_low_q     <= chr_low_d;
        chr_high_q    <= chr_high_d;
        chr_full_q    <= chr_full_d;
        prg_low_q     <= prg_low_d;
        prg_high_q    <= prg_high_d;
        prg_full_q    <= prg_full_d;
        mirror_q      <= mirror_d;
      end
    end
  end

endmodule

@@ design/sbsm_queue.sv @@
// ----------------------------------------------------------------------------
// sbsm_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sbsm_queue import sbsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/sbsm_back.sv @@
// ----------------------------------------------------------------------------
// sbsm_back
// Carries out queued commands: work RAM read or write, then holds the
// result word in an output register until it is taken.
// ----------------------------------------------------------------------------
module sbsm_back import sbsm_pkg::*; #(
  parameter int unsigned WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned RAM_AW = $clog2(WORK_RAM_BYTES);

  logic       res_valid_q, res_valid_d;
  cmd_t       res_cmd_q;
  logic       advance;
  logic [7:0] ram_rdata;

  assign advance     = !res_valid_q || !out_stall_i;
  assign q_pop_o     = q_valid_i && advance;
  assign res_valid_d = advance ? q_valid_i : res_valid_q;

  sbsm_ram #(
    .WIDTH (8),
    .DEPTH (WORK_RAM_BYTES)
  ) u_wram (
    .clk_i   (clk_i),
    .we_i    (q_pop_o && (q_cmd_i.op == OP_RAM_WR)),
    .re_i    (q_pop_o && (q_cmd_i.op == OP_RAM_RD)),
    .addr_i  (RAM_AW'(q_cmd_i.ram_addr)),
    .wdata_i (q_cmd_i.wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // Load the result register when it frees up
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_cmd_q <= q_cmd_i;
    end
  end

  // Form the result word
  assign out_valid_o               = res_valid_q;
  assign out_word_o.handled        = res_cmd_q.handled;
  assign out_word_o.to_rom         = res_cmd_q.to_rom;
  assign out_word_o.mapped_address = res_cmd_q.mapped;
  assign out_word_o.read_data      = (res_cmd_q.op == OP_RAM_RD) ? ram_rdata : 8'd0;
  assign out_word_o.mirroring      = res_cmd_q.mirror;

endmodule

@@ design/serial_bank_switch_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_unit
// Cartridge bank mapper: serial bank register loading, PRG/CHR address
// mapping and 8K work RAM, one bus word per cycle while in_stall_o is low.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o| in_word_i  (kind,addr,data)
//   out     | output    | out_valid_o/out_stall_i | out_word_o (result)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle is taken while in_stall_o is low; a result word passes
// through a queue slot, then the result register that also catches the
// work RAM read data, before it can be taken.
// A two-entry queue parts the front end from the back end; in_stall_o rises
// only when the queue is full, so an output stall reaches the input after
// the result register and both queue slots have filled.
// Reset clears the mapper registers and the pipeline; work RAM is not
// cleared and holds undefined bytes until written.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_unit import sbsm_pkg::*; #(
  parameter int unsigned WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i
);

  logic    take;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  cmd_t    front_cmd;
  cmd_t    q_head;
  cfg_wr_t cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{valid: cfg_valid_i && cfg_ready_o, index: cfg_index_i,
                         data: cfg_data_i};
  assign in_stall_o  = q_full;
  assign take        = in_valid_i && !q_full;

  sbsm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .take_i    (take),
    .in_word_i (in_word_i),
    .cmd_o     (front_cmd)
  );

  sbsm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  sbsm_back #(
    .WORK_RAM_BYTES (WORK_RAM_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // A ROM or CHR mapping is always a claimed access
  a_rom_claimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.to_rom |-> out_word_o.handled)
    else $error("to_rom set on an unclaimed access");

  // A nonzero mapped address only comes with to_rom
  a_map_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.mapped_address != '0) |-> out_word_o.to_rom)
    else $error("mapped address without to_rom");

  // Work RAM data only on claimed non-ROM accesses
  a_ram_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.read_data != '0)
      |-> out_word_o.handled && !out_word_o.to_rom)
    else $error("read data on a non work RAM access");

  // A popped queue entry always lands in the result register
  a_pop_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("queue pop lost");

endmodule

@@ tb/tb_serial_bank_switch_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// tb_serial_bank_switch_mapper_unit
// Self-checking bench for the serial bank switch mapper. A scoreboard class
// keeps its own copy of the mapper registers and work RAM, predicts every
// result word and compares it field by field. Stimulus is a short directed
// pass followed by random serial loads, bus accesses, clears and noise, run
// under several bank count settings with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_serial_bank_switch_mapper_unit;
  import sbsm_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned PHASE_WORDS    = 80;
  localparam int unsigned PHASE_COUNT    = 5;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  // Highest access kind code; the block ignores it
  localparam logic [2:0]  KIND_SPARE_TOP = 3'd7;

  // Scoreboard: mapper state copy, expected result words, field checks
  class bank_map_scoreboard;
    logic [4:0] prg_count;
    logic [5:0] chr_count;
    logic [4:0] shift_val;
    logic [2:0] shift_cnt;
    logic [4:0] ctrl;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [3:0] chr_8k;
    logic [3:0] prg_lo;
    logic [3:0] prg_hi;
    logic [2:0] prg_32k;
    logic [1:0] mirror;
    logic [7:0] work_ram [WORK_RAM_BYTES_DEF];
    out_word_t  pending_results[$];
    int unsigned errors;
    int unsigned compared;
    int unsigned bank_loads;

    function new();
      prg_count  = PRG_BANK_COUNT_RESET;
      chr_count  = CHR_BANK_COUNT_RESET;
      mirror     = MIRROR_RESET;
      errors     = 0;
      compared   = 0;
      bank_loads = 0;
      clear_banks();
    endfunction

    function logic [3:0] last_bank();
      logic [4:0] top;
      top = prg_count - 5'd1;
      return top[3:0];
    endfunction

    // Restore serial register, control and banks; keep RAM and mirroring
    function void clear_banks();
      shift_val = '0;
      shift_cnt = '0;
      ctrl      = CTRL_RESET;
      chr_lo    = '0;
      chr_hi    = '0;
      chr_8k    = '0;
      prg_lo    = '0;
      prg_hi    = last_bank();
      prg_32k   = '0;
    endfunction

    function void set_register(cfg_index_e idx, logic [5:0] value);
      if (idx == CFG_PRG_BANK_COUNT) begin
        prg_count = value[4:0];
      end else begin
        chr_count = value;
      end
    endfunction

    // Commit a full serial value to the register picked by the target
    function void load_bank(logic [1:0] tgt, logic [4:0] value);
      bank_loads++;
      case (target_e'(tgt))
        TGT_CONTROL: begin
          ctrl   = value;
          mirror = value[1:0];
        end
        TGT_CHR_LOW: begin
          if (ctrl[4]) chr_lo = value;
          else chr_8k = value[4:1];
        end
        TGT_CHR_HIGH: begin
          // 8K mode drops the high bank write
          if (ctrl[4]) chr_hi = value;
        end
        default: begin
          case (prg_mode_e'(ctrl[3:2]))
            PRG_MODE_32K_A, PRG_MODE_32K_B: prg_32k = value[3:1];
            PRG_MODE_FIX_LOW: begin
              prg_lo = '0;
              prg_hi = value[3:0];
            end
            default: begin
              prg_lo = value[3:0];
              prg_hi = last_bank();
            end
          endcase
        end
      endcase
    endfunction

    // Work out the result word of one bus word and advance the state
    function out_word_t map_access(in_word_t w);
      out_word_t  res;
      logic       in_wram;
      logic       in_chr;
      logic [3:0] pbank;
      logic [4:0] cbank;
      res     = '0;
      in_wram = (w.addr[15:13] == 3'b011);
      in_chr  = (w.addr[15:13] == 3'b000);
      case (w.kind)
        KIND_CPU_RD: begin
          if (in_wram) begin
            res.handled   = 1'b1;
            res.read_data = work_ram[w.addr[12:0]];
          end else if (w.addr[15]) begin
            res.handled = 1'b1;
            res.to_rom  = 1'b1;
            if (ctrl[3]) begin
              pbank = w.addr[14] ? prg_hi : prg_lo;
              res.mapped_address = {pbank, w.addr[13:0]};
            end else begin
              res.mapped_address = {prg_32k, w.addr[14:0]};
            end
          end
        end
        KIND_CPU_WR: begin
          if (in_wram) begin
            res.handled = 1'b1;
            work_ram[w.addr[12:0]] = w.write_data;
          end else if (w.addr[15]) begin
            res.handled = 1'b1;
            if (w.write_data[7]) begin
              // Clear the serial register and force the fixed-high PRG mode
              shift_val = '0;
              shift_cnt = '0;
              ctrl      = ctrl | CTRL_PRG_MODE_FORCE;
            end else begin
              shift_val = {w.write_data[0], shift_val[4:1]};
              if (shift_cnt == SHIFT_LAST) begin
                load_bank(w.addr[14:13], shift_val);
                shift_val = '0;
                shift_cnt = '0;
              end else begin
                shift_cnt = shift_cnt + 3'd1;
              end
            end
          end
        end
        KIND_PPU_RD: begin
          if (in_chr) begin
            res.handled = 1'b1;
            res.to_rom  = 1'b1;
            if (chr_count == '0) begin
              res.mapped_address = w.addr;
            end else if (ctrl[4]) begin
              cbank = w.addr[12] ? chr_hi : chr_lo;
              res.mapped_address = {cbank, w.addr[11:0]};
            end else begin
              res.mapped_address = {chr_8k, w.addr[12:0]};
            end
          end
        end
        KIND_PPU_WR: begin
          // Only CHR RAM accepts writes
          if (in_chr && chr_count == '0) begin
            res.handled        = 1'b1;
            res.to_rom         = 1'b1;
            res.mapped_address = w.addr;
          end
        end
        KIND_CART_RST: clear_banks();
        default: ;
      endcase
      res.mirroring = mirror;
      return res;
    endfunction

    function void note_access(in_word_t w);
      pending_results.push_back(map_access(w));
    endfunction

    function void compare_field(string field, logic [17:0] want, logic [17:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      compared++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("handled", want.handled, got.handled);
      compare_field("to_rom", want.to_rom, got.to_rom);
      compare_field("mapped_address", want.mapped_address, got.mapped_address);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("mirroring", want.mirroring, got.mirroring);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_word_t   in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [5:0] cfg_data_i  = '0;

  bank_map_scoreboard sb = new();

  bit          steady;
  bit          ram_written [WORK_RAM_BYTES_DEF];
  logic [12:0] written_offsets[$];
  int unsigned words_sent;
  int unsigned settings_done;
  int unsigned stall_left;

  serial_bank_switch_mapper_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_word_i,
    .out_valid_o,
    .out_stall_i,
    .out_word_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(15, 40);
  endfunction

  // Check accepted result words, then pick the next output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
    if (stall_left != 0) stall_left--;
    else if (!steady && $urandom_range(0, 4) == 0) stall_left = idle_length();
    out_stall_i <= (stall_left != 0);
  end

  // Hold one bus word until accepted, then maybe idle
  task automatic send_word(in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_access(w);
    words_sent++;
    if (!steady && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat (idle_length()) @(posedge clk_i);
    end
  endtask

  // Build a bus word; steer work RAM reads onto bytes already written
  task automatic send_access(logic [2:0] kind, logic [15:0] addr, logic [7:0] data);
    in_word_t w;
    if (kind == KIND_CPU_RD && addr[15:13] == 3'b011 && !ram_written[addr[12:0]]) begin
      if (written_offsets.size() != 0)
        addr = {3'b011, written_offsets[$urandom_range(0, written_offsets.size() - 1)]};
      else
        addr[15] = 1'b1;
    end
    if (kind == KIND_CPU_WR && addr[15:13] == 3'b011 && !ram_written[addr[12:0]]) begin
      ram_written[addr[12:0]] = 1'b1;
      written_offsets.push_back(addr[12:0]);
    end
    w.kind       = kind;
    w.addr       = addr;
    w.write_data = data;
    send_word(w);
  endtask

  // One access that leaves the serial register alone
  task automatic bus_access();
    int unsigned r;
    logic [15:0] a;
    r = $urandom_range(0, 9);
    a = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h1FFF));
    if (r < 3) send_access(KIND_CPU_RD, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
    else if (r == 3) send_access(KIND_CPU_RD, {3'b011, 13'($urandom)}, 8'($urandom));
    else if (r < 6) send_access(KIND_CPU_WR, {3'b011, 13'($urandom)}, 8'($urandom));
    else if (r < 9) send_access(KIND_PPU_RD, a, 8'($urandom));
    else send_access(KIND_PPU_WR, a, 8'($urandom));
  endtask

  // Shift five bits LSB first into the serial register, last word picks target
  task automatic load_serial(target_e tgt, logic [4:0] value, bit mixed);
    logic [15:0] a;
    for (int i = 0; i < 5; i++) begin
      a = {1'b1, tgt, 13'($urandom)};
      if (i < 4 && $urandom_range(0, 3) == 0) a[14:13] = 2'($urandom);
      send_access(KIND_CPU_WR, a, {1'b0, 6'($urandom), value[i]});
      if (mixed && i < 4 && $urandom_range(0, 2) == 0) bus_access();
    end
  endtask

  task automatic write_register(cfg_index_e idx, logic [5:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_register(idx, value);
  endtask

  // Drain the block, then write both bank counts
  task automatic set_bank_counts(logic [5:0] prg, logic [5:0] chr);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    write_register(CFG_PRG_BANK_COUNT, prg);
    write_register(CFG_CHR_BANK_COUNT, chr);
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  task automatic random_episode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) steady = !steady;
    if (r < 35) begin
      load_serial(target_e'($urandom_range(0, 3)), 5'($urandom), 1'($urandom));
    end else if (r < 65) begin
      repeat ($urandom_range(1, 6)) bus_access();
    end else if (r < 73) begin
      send_access(KIND_CPU_WR, 16'($urandom_range(16'h8000, 16'hFFFF)),
                  {1'b1, 7'($urandom)});
    end else if (r < 77) begin
      send_access(KIND_CART_RST, 16'($urandom), 8'($urandom));
    end else if (r < 92) begin
      send_access(3'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      // Leave a partial serial value behind
      repeat ($urandom_range(1, 4))
        send_access(KIND_CPU_WR, 16'($urandom_range(16'h8000, 16'hFFFF)),
                    {1'b0, 7'($urandom)});
    end
  endtask

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL serial_bank_switch_mapper_unit");
    $finish;
  end

  initial begin
    logic [5:0]  prg_set;
    logic [5:0]  chr_set;
    int unsigned phase_end;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass: reset banks, CHR RAM, first and last work RAM bytes, unclaimed words
    set_bank_counts(6'd16, 6'd0);
    send_access(KIND_CPU_RD, 16'h8000, 8'h00);
    send_access(KIND_CPU_RD, 16'hFFFF, 8'hFF);
    send_access(KIND_PPU_RD, 16'h0000, 8'h00);
    send_access(KIND_PPU_RD, 16'h1FFF, 8'h00);
    send_access(KIND_PPU_WR, 16'h1FFF, 8'hFF);
    send_access(KIND_CPU_WR, 16'h6000, 8'hFF);
    send_access(KIND_CPU_WR, 16'h7FFF, 8'h00);
    send_access(KIND_CPU_RD, 16'h6000, 8'h00);
    send_access(KIND_CPU_RD, 16'h7FFF, 8'h00);
    send_access(KIND_CPU_RD, 16'h5FFF, 8'h00);
    send_access(KIND_PPU_RD, 16'h2000, 8'h00);
    send_access(KIND_SPARE_TOP, 16'hFFFF, 8'hFF);
    send_access(KIND_CPU_WR, 16'hFFFF, 8'h80);
    // 8K CHR, PRG fixed-low mode, mirroring code 2; then a dropped high bank
    load_serial(TGT_CONTROL, 5'b01010, 1'b0);
    load_serial(TGT_CHR_HIGH, 5'h1F, 1'b0);
    send_access(KIND_CPU_RD, 16'hC000, 8'h00);
    send_access(KIND_CART_RST, 16'h0000, 8'h00);

    // Random phases, bank counts at both ends of their range and past them
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin prg_set = 6'd1;  chr_set = 6'd32; end
        1: begin prg_set = 6'd0;  chr_set = 6'd1;  end
        2: begin prg_set = 6'h3F; chr_set = 6'h3F; end
        3: begin
          prg_set = 6'($urandom_range(1, 16));
          chr_set = 6'($urandom_range(0, 32));
        end
        default: begin prg_set = 6'd16; chr_set = 6'd0; end
      endcase
      set_bank_counts(prg_set, chr_set);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) random_episode();
    end

    // Drain and let any stray word surface
    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d bus words under %0d bank count settings, %0d bank register loads.",
             words_sent, settings_done, sb.bank_loads);
    $display("Compared %0d result words, %0d field mismatches.", sb.compared, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS serial_bank_switch_mapper_unit");
    end else begin
      $display("FAIL serial_bank_switch_mapper_unit");
    end
    $finish;
  end

endmodule
